// ----- hdl/u8u16_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16 (BMP) decoder.
package u8u16_pkg;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int ACC_W   = 21;

    localparam logic [UNIT_W-1:0] C_MAX_UNITS_RST = 16'd256;
    localparam logic [UNIT_W-1:0] C_UNIT_QMARK    = 16'h003F;
    localparam logic [UNIT_W-1:0] C_UNIT_TERM     = 16'h0000;
    localparam logic [ACC_W-1:0]  C_BMP_MAX       = 21'h00FFFF;
    localparam logic [1:0]        C_CONT_TAG      = 2'b10;

    // One decoded result leaving the decode stage
    typedef struct packed {
        logic              valid;
        logic [UNIT_W-1:0] unit;
        logic              last;
    } t_result;

endpackage

// ----- hdl/u8u16_in_stage.sv -----
// Input register stage: holds one accepted byte until the decoder takes it.
module u8u16_in_stage
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_step,
    output logic              o_ready,
    output logic              o_valid,
    output logic [BYTE_W-1:0] o_byte
);

    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              n_valid;

    // Take a new byte when empty or when the held one moves on
    assign o_ready = !r_valid || i_step;
    assign n_valid = (i_valid && o_ready) ? 1'b1 : (i_step ? 1'b0 : r_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ----- hdl/u8u16_decode.sv -----
// Sequence decoder: holds string and sequence state, forms at most one unit per byte.
module u8u16_decode
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [UNIT_W-1:0] i_cfg_data,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_res
);

    logic [UNIT_W-1:0] r_max_units;
    logic [1:0]        r_bytes_pending, n_bytes_pending;
    logic [1:0]        r_seq_length,    n_seq_length;
    logic [ACC_W-1:0]  r_code_accum,    n_code_accum;
    logic              r_cont_bad,      n_cont_bad;
    logic [UNIT_W-1:0] r_units_sent,    n_units_sent;
    logic              r_dropping,      n_dropping;

    logic              want_term;
    logic              want_unit;
    logic [UNIT_W-1:0] unit_val;
    logic [UNIT_W-1:0] cap_m1;
    logic [ACC_W-1:0]  acc_shift;
    logic              bad_now;
    logic [1:0]        pend_dec;

    // Last usable slot index; a zero cap acts as one
    assign cap_m1 = (r_max_units == '0) ? '0 : (r_max_units - 16'd1);

    // Continuation byte folded into the accumulator
    assign acc_shift = {r_code_accum[ACC_W-7:0], i_byte[5:0]};
    assign bad_now   = r_cont_bad ||
                       ((r_seq_length >= 2'd2) && (i_byte[7:6] != C_CONT_TAG));
    assign pend_dec  = r_bytes_pending - 2'd1;

    // Next state and result for the byte at the decode stage
    always_comb begin
        n_bytes_pending = r_bytes_pending;
        n_seq_length    = r_seq_length;
        n_code_accum    = r_code_accum;
        n_cont_bad      = r_cont_bad;
        n_units_sent    = r_units_sent;
        n_dropping      = r_dropping;
        want_term       = 1'b0;
        want_unit       = 1'b0;
        unit_val        = C_UNIT_QMARK;
        o_res           = '{valid: 1'b0, unit: C_UNIT_TERM, last: 1'b0};

        if (r_dropping) begin
            // Discard up to and including the next zero
            if (i_byte == '0) begin
                n_dropping      = 1'b0;
                n_units_sent    = '0;
                n_bytes_pending = '0;
                n_seq_length    = '0;
                n_code_accum    = '0;
                n_cont_bad      = 1'b0;
            end
        end else if (r_bytes_pending != '0) begin
            if (i_byte == '0) begin
                want_term = 1'b1;
            end else if (pend_dec != '0) begin
                n_cont_bad      = bad_now;
                n_code_accum    = acc_shift;
                n_bytes_pending = pend_dec;
            end else begin
                want_unit = 1'b1;
                if (bad_now || acc_shift == '0 || acc_shift > C_BMP_MAX) begin
                    unit_val = C_UNIT_QMARK;
                end else begin
                    unit_val = acc_shift[UNIT_W-1:0];
                end
                n_bytes_pending = '0;
                n_seq_length    = '0;
                n_code_accum    = '0;
                n_cont_bad      = 1'b0;
            end
        end else begin
            case (i_byte) inside
                8'h00: begin
                    want_term = 1'b1;
                end
                [8'h01:8'h7F]: begin
                    want_unit = 1'b1;
                    unit_val  = {8'h00, i_byte};
                end
                [8'hC0:8'hDF]: begin
                    n_seq_length    = 2'd1;
                    n_bytes_pending = 2'd1;
                    n_code_accum    = {16'h0000, i_byte[4:0]};
                    n_cont_bad      = 1'b0;
                end
                [8'hE0:8'hEF]: begin
                    n_seq_length    = 2'd2;
                    n_bytes_pending = 2'd2;
                    n_code_accum    = {17'h00000, i_byte[3:0]};
                    n_cont_bad      = 1'b0;
                end
                [8'hF0:8'hF7]: begin
                    n_seq_length    = 2'd3;
                    n_bytes_pending = 2'd3;
                    n_code_accum    = {18'h00000, i_byte[2:0]};
                    n_cont_bad      = 1'b0;
                end
                default: begin
                    want_unit = 1'b1;
                    unit_val  = C_UNIT_QMARK;
                end
            endcase
        end

        // Cap check: the unit that would fill the last slot turns into the terminator
        if (want_unit && (r_units_sent >= cap_m1)) begin
            n_dropping = 1'b1;
            want_term  = 1'b1;
        end

        if (want_term) begin
            o_res           = '{valid: 1'b1, unit: C_UNIT_TERM, last: 1'b1};
            n_units_sent    = '0;
            n_bytes_pending = '0;
            n_seq_length    = '0;
            n_code_accum    = '0;
            n_cont_bad      = 1'b0;
        end else if (want_unit) begin
            o_res        = '{valid: 1'b1, unit: unit_val, last: 1'b0};
            n_units_sent = r_units_sent + 16'd1;
        end
    end

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_units <= C_MAX_UNITS_RST;
        end else if (i_cfg_we) begin
            r_max_units <= i_cfg_data;
        end
    end

    // Advance state once per byte taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_pending <= '0;
            r_seq_length    <= '0;
            r_code_accum    <= '0;
            r_cont_bad      <= 1'b0;
            r_units_sent    <= '0;
            r_dropping      <= 1'b0;
        end else if (i_step) begin
            r_bytes_pending <= n_bytes_pending;
            r_seq_length    <= n_seq_length;
            r_code_accum    <= n_code_accum;
            r_cont_bad      <= n_cont_bad;
            r_units_sent    <= n_units_sent;
            r_dropping      <= n_dropping;
        end
    end

    // Terminator always carries a zero unit
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> (o_res.unit == C_UNIT_TERM))
        else $error("terminator with nonzero unit");

    // Nothing comes out while dropping
    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dropping |-> !o_res.valid)
        else $error("result produced while dropping");

    // Pending count never exceeds the sequence length
    a_pend_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_pending <= r_seq_length)
        else $error("pending count above sequence length");

    // A terminator restarts the string count and the sequence
    a_term_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.valid && o_res.last) |=>
            (r_units_sent == '0 && r_bytes_pending == '0))
        else $error("state not cleared after terminator");

endmodule

// ----- hdl/u8u16_out_stage.sv -----
// Output register stage: holds one code unit until the downstream side takes it.
module u8u16_out_stage
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_result           i_res,
    input  logic              i_ready,
    output logic              o_free,
    output logic              o_valid,
    output logic [UNIT_W-1:0] o_unit,
    output logic              o_last
);

    logic              r_valid;
    logic [UNIT_W-1:0] r_unit;
    logic              r_last;

    // Free when empty or when the held unit leaves this cycle
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_unit <= i_res.unit;
            r_last <= i_res.last;
        end
    end

    assign o_valid = r_valid;
    assign o_unit  = r_unit;
    assign o_last  = r_last;

endmodule

// ----- hdl/utf8_to_utf16_bmp_decoder.sv -----
// Top level of the UTF-8 to UTF-16 (BMP) stream decoder.
//
//  Channel   Direction  Payload (low bit up)           Transaction
//  s_axis    in         tdata[7:0] = in_byte            tvalid & tready
//  m_axis    out        tdata[15:0] = code_unit,        tvalid & tready
//                       tlast = is_last
//  cfg       in         i_cfg_wr_data[15:0] = max_units i_cfg_wr_en
//
// One byte per cycle sustained while m_axis does not stall; a byte's result passes from
// the input register through the decode stage into the output register, then onto m_axis.
// The sequence state updates once per byte at the decode stage.
// Synchronous active-low reset clears control state; max_units returns to 256.
// A stall on m_axis holds the decode stage; s_axis_tready falls once the input register is full.
module utf8_to_utf16_bmp_decoder
    import u8u16_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [UNIT_W-1:0] i_cfg_wr_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,   // [7:0] in_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [UNIT_W-1:0] m_axis_tdata,   // [15:0] code_unit
    output logic              m_axis_tlast    // is_last
);

    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    logic              out_free;
    logic              step;
    t_result           res;

    // Decode one held byte whenever the output register can take its result
    assign step = in_valid && out_free;

    u8u16_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_step  (step),
        .o_ready (s_axis_tready),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    u8u16_decode u_dec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_wr_en),
        .i_cfg_data (i_cfg_wr_data),
        .i_step     (step),
        .i_byte     (in_byte),
        .o_res      (res)
    );

    u8u16_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res.valid),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .o_unit  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for the UTF-8 to UTF-16 stream decoder: directed table, random text, cap settings.
`timescale 1ns / 1ps

module testbench
    import u8u16_pkg::*;
();

    localparam int   N_DIRECTED  = 26;
    localparam int   N_PHASES    = 10;
    localparam int   PHASE_BYTES = 200;
    localparam int   SETTLE      = 6;
    localparam int   HOLD_CYCLES = 120;
    localparam int   QUIET_LIMIT = 3000;
    localparam logic ROW_TYPED   = 1'b1;
    localparam logic ROW_PREDICT = 1'b0;

    localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;
    localparam t_result R_NONE  = '0;
    localparam t_result R_TERM  = {1'b1, C_UNIT_TERM, 1'b1};
    localparam t_result R_QMARK = {1'b1, C_UNIT_QMARK, 1'b0};

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              typed;
        t_result           want;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [UNIT_W-1:0] i_cfg_wr_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata;   // [7:0] in_byte
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [UNIT_W-1:0] m_axis_tdata;   // [15:0] code_unit
    logic              m_axis_tlast;   // is_last

    // Decoder state mirrored on the bench side
    logic [1:0]        dec_pending;
    logic [1:0]        dec_seq_len;
    logic [ACC_W-1:0]  dec_accum;
    logic              dec_bad;
    logic [UNIT_W-1:0] dec_sent;
    logic              dec_dropping;
    logic [UNIT_W-1:0] dec_max_units;

    t_result           pending_units[$];
    logic [BYTE_W-1:0] text_bytes[$];
    t_result           unit_want;

    int errors         = 0;
    int bytes_in       = 0;
    int units_checked  = 0;
    int terms_checked  = 0;
    int quiet_cycles   = 0;
    int snd_idle_pct   = 0;
    int rcv_idle_pct   = 0;
    int settings_used  = 1;
    bit hold_req       = 1'b0;

    // Directed rows: ASCII extremes, 2/3/4-byte forms, bad continuation,
    // out-of-range and zero code points, bad leads, zero inside a sequence
    t_row directed_rows [N_DIRECTED] = '{
        {8'h41, ROW_TYPED,   1'b1, 16'h0041, 1'b0},
        {8'h01, ROW_TYPED,   1'b1, 16'h0001, 1'b0},
        {8'h7F, ROW_TYPED,   1'b1, 16'h007F, 1'b0},
        {8'hC3, ROW_TYPED,   R_NONE},
        {8'h29, ROW_PREDICT, R_NONE},
        {8'hE2, ROW_PREDICT, R_NONE},
        {8'h82, ROW_PREDICT, R_NONE},
        {8'hAC, ROW_PREDICT, R_NONE},
        {8'hE2, ROW_PREDICT, R_NONE},
        {8'h41, ROW_PREDICT, R_NONE},
        {8'hAC, ROW_PREDICT, R_NONE},
        {8'hF0, ROW_PREDICT, R_NONE},
        {8'h9F, ROW_PREDICT, R_NONE},
        {8'h98, ROW_PREDICT, R_NONE},
        {8'h80, ROW_PREDICT, R_NONE},
        {8'hE0, ROW_PREDICT, R_NONE},
        {8'h80, ROW_PREDICT, R_NONE},
        {8'h80, ROW_PREDICT, R_NONE},
        {8'hEF, ROW_PREDICT, R_NONE},
        {8'hBF, ROW_PREDICT, R_NONE},
        {8'hBF, ROW_PREDICT, R_NONE},
        {8'h80, ROW_TYPED,   R_QMARK},
        {8'hFF, ROW_TYPED,   R_QMARK},
        {8'hE2, ROW_TYPED,   R_NONE},
        {8'h00, ROW_TYPED,   R_TERM},
        {8'h00, ROW_TYPED,   R_TERM}
    };

    logic [UNIT_W-1:0] phase_max [N_PHASES] = '{
        16'd3, 16'd1, 16'd65535, 16'd0, 16'd2, 16'd7, 16'd256, 16'd12, 16'd65535, 16'd4
    };

    utf8_to_utf16_bmp_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Drop any partial sequence
    task automatic clear_sequence();
        dec_pending = '0;
        dec_seq_len = '0;
        dec_accum   = '0;
        dec_bad     = 1'b0;
    endtask

    // Append one byte to the text waiting to be sent
    task automatic queue_byte(input logic [BYTE_W-1:0] b);
        text_bytes = {text_bytes, b};
    endtask

    // Advance the decoder mirror by one byte and return the unit it yields
    task automatic decode_byte(input logic [BYTE_W-1:0] b, output t_result r);
        logic              emit;
        logic [UNIT_W-1:0] code;
        logic [UNIT_W:0]   cap;
        r    = R_NONE;
        emit = 1'b0;
        code = C_UNIT_TERM;
        if (dec_dropping) begin
            if (b == NUL_BYTE) begin
                dec_dropping = 1'b0;
                dec_sent     = '0;
                clear_sequence();
            end
        end else if (b == NUL_BYTE) begin
            r        = R_TERM;
            dec_sent = '0;
            clear_sequence();
        end else if (dec_pending != 0) begin
            if (dec_seq_len >= 2 && b[7:6] != C_CONT_TAG)
                dec_bad = 1'b1;
            dec_accum   = {dec_accum[ACC_W-7:0], b[5:0]};
            dec_pending = dec_pending - 1'b1;
            if (dec_pending == 0) begin
                if (dec_bad || dec_accum == 0 || dec_accum > C_BMP_MAX)
                    code = C_UNIT_QMARK;
                else
                    code = dec_accum[UNIT_W-1:0];
                clear_sequence();
                emit = 1'b1;
            end
        end else if (b <= 8'h7F) begin
            code = {8'h00, b};
            emit = 1'b1;
        end else if (b[7:5] == 3'b110) begin
            dec_seq_len = 2'd1;
            dec_pending = 2'd1;
            dec_accum   = ACC_W'(b[4:0]);
            dec_bad     = 1'b0;
        end else if (b[7:4] == 4'b1110) begin
            dec_seq_len = 2'd2;
            dec_pending = 2'd2;
            dec_accum   = ACC_W'(b[3:0]);
            dec_bad     = 1'b0;
        end else if (b[7:3] == 5'b11110) begin
            dec_seq_len = 2'd3;
            dec_pending = 2'd3;
            dec_accum   = ACC_W'(b[2:0]);
            dec_bad     = 1'b0;
        end else begin
            code = C_UNIT_QMARK;
            emit = 1'b1;
        end

        // Replace the unit that fills the last slot by the terminator
        if (emit) begin
            cap = (dec_max_units == 0) ? (UNIT_W+1)'(1) : {1'b0, dec_max_units};
            if ({1'b0, dec_sent} >= cap - 1'b1) begin
                dec_dropping = 1'b1;
                r            = R_TERM;
                dec_sent     = '0;
                clear_sequence();
            end else begin
                r        = {1'b1, code, 1'b0};
                dec_sent = dec_sent + 1'b1;
            end
        end
    endtask

    // Offer one byte, hold it until the transaction, then record what it should give
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                             input t_result want);
        t_result r;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        decode_byte(b, r);
        if (typed)
            r = want;
        if (r.valid)
            pending_units = {pending_units, r};
        bytes_in++;
    endtask

    // Add continuation bytes, now and then a corrupted or zero one
    task automatic add_cont(input int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                queue_byte(NUL_BYTE);
            else if (pick < 12)
                queue_byte(BYTE_W'($urandom_range(1, 255)));
            else
                queue_byte(8'h80 | BYTE_W'($urandom_range(0, 63)));
        end
    endtask

    // Build strings of mostly well-formed UTF-8, ending mid-string
    task automatic add_random_text(input int n_bytes);
        int target;
        int n_chars;
        int kind;
        target = text_bytes.size() + n_bytes;
        while (text_bytes.size() < target) begin
            n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 10);
            repeat (n_chars) begin
                kind = $urandom_range(0, 99);
                if (kind < 40) begin
                    queue_byte(BYTE_W'($urandom_range(1, 127)));
                end else if (kind < 58) begin
                    queue_byte(8'hC0 | BYTE_W'($urandom_range(0, 31)));
                    add_cont(1);
                end else if (kind < 76) begin
                    queue_byte(8'hE0 | BYTE_W'($urandom_range(0, 15)));
                    add_cont(2);
                end else if (kind < 86) begin
                    queue_byte(8'hF0 | BYTE_W'($urandom_range(0, 7)));
                    add_cont(3);
                end else if (kind < 92) begin
                    if ($urandom_range(0, 1))
                        queue_byte(BYTE_W'($urandom_range(8'h80, 8'hBF)));
                    else
                        queue_byte(BYTE_W'($urandom_range(8'hF8, 8'hFF)));
                end else begin
                    // Truncated sequence: the next character runs into it
                    if ($urandom_range(0, 1)) begin
                        queue_byte(8'hE0 | BYTE_W'($urandom_range(0, 15)));
                        add_cont($urandom_range(0, 1));
                    end else begin
                        queue_byte(8'hF0 | BYTE_W'($urandom_range(0, 7)));
                        add_cont($urandom_range(0, 2));
                    end
                end
            end
            if ($urandom_range(0, 9) != 0)
                queue_byte(NUL_BYTE);
        end
        repeat ($urandom_range(1, 4))
            queue_byte(BYTE_W'($urandom_range(8'h20, 8'h7E)));
    endtask

    // Lower valid and wait until every expected unit has come out
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_units.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_max_units(input logic [UNIT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        dec_max_units = value;
        settings_used++;
    endtask

    // Receiver: random ready, with one long hold on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // Compare each output transaction with the oldest expected unit; watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_units.size() == 0) begin
                    $error("unexpected code unit %h (last %b)", m_axis_tdata, m_axis_tlast);
                    errors++;
                end else begin
                    unit_want = pending_units.pop_front();
                    if (m_axis_tdata !== unit_want.unit) begin
                        $error("code_unit: expected %h, got %h", unit_want.unit, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tlast !== unit_want.last) begin
                        $error("is_last: expected %b, got %b", unit_want.last, m_axis_tlast);
                        errors++;
                    end
                    units_checked++;
                    if (unit_want.last)
                        terms_checked++;
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    // Main sequence: reset, directed table, then random phases per cap setting
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        dec_max_units = C_MAX_UNITS_RST;
        dec_dropping  = 1'b0;
        dec_sent      = '0;
        clear_sequence();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 15;
        rcv_idle_pct = 81;
        for (int i = 0; i < N_DIRECTED; i++)
            send_byte(directed_rows[i].in_byte, directed_rows[i].typed,
                      directed_rows[i].want);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 3) begin
                snd_idle_pct = 15;
                rcv_idle_pct = 81;
            end else if (p < 6) begin
                snd_idle_pct = 81;
                rcv_idle_pct = 15;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            write_max_units(phase_max[p]);
            add_random_text(PHASE_BYTES);
            // Hold the output long enough to back up the input side
            if (p == 7)
                hold_req = 1'b1;
            while (text_bytes.size() != 0)
                send_byte(text_bytes.pop_front(), ROW_PREDICT, R_NONE);
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("Covered %0d bytes over %0d cap settings (1, 65535 and 0 among them).",
                 bytes_in, settings_used);
        $display("Checked %0d code units, %0d of them terminators, plus a %0d-cycle output hold.",
                 units_checked, terms_checked, HOLD_CYCLES);
        if (errors == 0 && pending_units.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/u8u16_pkg.sv
hdl/u8u16_in_stage.sv
hdl/u8u16_decode.sv
hdl/u8u16_out_stage.sv
hdl/utf8_to_utf16_bmp_decoder.sv
bench/testbench.sv
